/* design/assert_macros.svh */
// Assertion macros used by the classifier core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising clock edge outside reset
`define BDPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition in one cycle implies a consequence in the next
`define BDPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BDPC_ASSERT(lbl, clk, rst_n, prop)
`define BDPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/bdpc_pkg.sv */
// Types and constants for the button debounce and press classifier
`timescale 1ns / 1ps

package bdpc_pkg;

    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    typedef enum logic {
        OP_INIT   = 1'b0,
        OP_SAMPLE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } press_event_t;

    // Configuration register indexes
    localparam logic CFG_DEBOUNCE_TIME   = 1'b0;
    localparam logic CFG_LONG_PRESS_TIME = 1'b1;

    localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST   = 16'd30;
    localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST = 16'd1000;

    typedef struct packed {
        opcode_t             opcode;
        logic                pressed_level;
        logic [TIME_W-1:0]   now_time;
    } item_t;

endpackage

/* design/button_debounce_press_classifier.sv */
// Top level: input register, classifier core and result register
//
// Button debounce and short/long press classifier.
// Slave channel (s_): one beat per raw button sample. s_tuser carries the
// opcode (0 = initialise state, 1 = process sample); s_tdata carries the
// raw level and a 32-bit wrapping millisecond timestamp.
// Master channel (m_): exactly one result beat per input beat, in order,
// carrying the press event (0 none, 1 short press, 2 long press).
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 = debounce time, 1 = long-press time); write only while idle.
// An accepted beat moves from the input register to the result register.
// Throughput: one beat per cycle while m_tready is high; the state update
// is one pass of short logic between the input and result registers.
// Reset (aresetn low, synchronous): state cleared, debounce time 30 ms,
// long-press time 1000 ms, both channels empty.
// When m_tready is low the result is held; the input register still takes
// one further beat, then s_tready drops until the result is taken.
`timescale 1ns / 1ps

module button_debounce_press_classifier
    import bdpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [0] pressed_level, [32:1] now_time, rest zero
    input  logic                  s_tuser,   // [0] opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // [1:0] press_event, rest zero
);

    logic          in_valid_reg, in_valid_next;
    item_t         in_item_reg;
    logic          m_valid_reg, m_valid_next;
    press_event_t  m_event_reg;
    press_event_t  core_event;
    logic          advance;
    logic          s_accept;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next = s_accept || (in_valid_reg && !advance);
    assign m_valid_next  = advance || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // capture the incoming beat
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.opcode        <= opcode_t'(s_tuser);
            in_item_reg.pressed_level <= s_tdata[0];
            in_item_reg.now_time      <= s_tdata[TIME_W:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_event_reg <= core_event;
        end
    end

    bdpc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .advance     (advance),
        .item        (in_item_reg),
        .press_event (core_event)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-2){1'b0}}, m_event_reg};

endmodule

/* design/bdpc_core.sv */
// Debounce state, configuration registers and press classification logic
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdpc_core
    import bdpc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               advance,
    input  item_t              item,
    output press_event_t       press_event
);

    logic [CFG_W-1:0]  debounce_time_reg;
    logic [CFG_W-1:0]  long_press_time_reg;

    logic              raw_level_seen_reg,       raw_level_seen_next;
    logic              stable_level_reg,         stable_level_next;
    logic              ignore_until_release_reg, ignore_until_release_next;
    logic [TIME_W-1:0] change_time_reg,          change_time_next;
    logic [TIME_W-1:0] press_start_time_reg,     press_start_time_next;

    logic [TIME_W-1:0] deadline_diff;
    logic [TIME_W-1:0] held_time;
    logic              deadline_reached;
    logic              held_long;
    press_event_t      event_comb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_time_reg   <= DEBOUNCE_TIME_RST;
            long_press_time_reg <= LONG_PRESS_TIME_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DEBOUNCE_TIME:   debounce_time_reg   <= cfg_wdata;
                CFG_LONG_PRESS_TIME: long_press_time_reg <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    // now - (change_time + debounce_time), wrap-safe via the sign bit
    assign deadline_diff    = item.now_time - change_time_reg
                              - {{(TIME_W-CFG_W){1'b0}}, debounce_time_reg};
    assign deadline_reached = !deadline_diff[TIME_W-1];
    assign held_time        = item.now_time - press_start_time_reg;
    assign held_long        = held_time >= {{(TIME_W-CFG_W){1'b0}}, long_press_time_reg};

    always_comb begin
        raw_level_seen_next       = raw_level_seen_reg;
        stable_level_next         = stable_level_reg;
        ignore_until_release_next = ignore_until_release_reg;
        change_time_next          = change_time_reg;
        press_start_time_next     = press_start_time_reg;
        event_comb                = EV_NONE;
        if (item.opcode == OP_INIT) begin
            raw_level_seen_next       = item.pressed_level;
            stable_level_next         = item.pressed_level;
            ignore_until_release_next = item.pressed_level;
            change_time_next          = item.now_time;
            press_start_time_next     = item.now_time;
        end else if (long_press_time_reg != '0) begin
            // any raw change restarts the debounce timer
            if (item.pressed_level != raw_level_seen_reg) begin
                raw_level_seen_next = item.pressed_level;
                change_time_next    = item.now_time;
            end else if (item.pressed_level != stable_level_reg && deadline_reached) begin
                stable_level_next = item.pressed_level;
                if (item.pressed_level) begin
                    if (!ignore_until_release_reg) begin
                        press_start_time_next = item.now_time;
                    end
                end else if (ignore_until_release_reg) begin
                    ignore_until_release_next = 1'b0;
                end else begin
                    event_comb = held_long ? EV_LONG : EV_SHORT;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_level_seen_reg       <= 1'b0;
            stable_level_reg         <= 1'b0;
            ignore_until_release_reg <= 1'b0;
            change_time_reg          <= '0;
            press_start_time_reg     <= '0;
        end else if (advance) begin
            raw_level_seen_reg       <= raw_level_seen_next;
            stable_level_reg         <= stable_level_next;
            ignore_until_release_reg <= ignore_until_release_next;
            change_time_reg          <= change_time_next;
            press_start_time_reg     <= press_start_time_next;
        end
    end

    assign press_event = event_comb;

    // an ignored press always has the debounced level held
    `BDPC_ASSERT(a_ignore_implies_held, aclk, aresetn,
                 !ignore_until_release_reg || stable_level_reg)
    // events come only from a debounced release of a sample
    `BDPC_ASSERT(a_event_on_release, aclk, aresetn,
                 (press_event == EV_NONE) ||
                 (item.opcode == OP_SAMPLE && !item.pressed_level && stable_level_reg))
    `BDPC_ASSERT_NEXT(a_disabled_holds_state, aclk, aresetn,
                      advance && item.opcode == OP_SAMPLE && long_press_time_reg == '0,
                      $stable(raw_level_seen_reg) && $stable(stable_level_reg) &&
                      $stable(change_time_reg) && $stable(press_start_time_reg))
    `BDPC_ASSERT_NEXT(a_init_loads_levels, aclk, aresetn,
                      advance && item.opcode == OP_INIT,
                      raw_level_seen_reg == stable_level_reg &&
                      ignore_until_release_reg == stable_level_reg)

endmodule

/* tb/press_classifier_checker.sv */
// Checker for the press classifier: predicts each press event and compares result beats
`timescale 1ns / 1ps

module press_classifier_checker
    import bdpc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  mismatch_total,
    output int                  pending_results,
    output int                  results_checked,
    output int                  short_presses,
    output int                  long_presses
);

    logic [CFG_W-1:0]  deb_window;
    logic [CFG_W-1:0]  hold_limit;
    logic              raw_seen;
    logic              debounced;
    logic              ignore_press;
    logic [TIME_W-1:0] change_at;
    logic [TIME_W-1:0] press_at;
    press_event_t      pending_events[$];
    int                mismatches;
    int                checked;
    int                shorts;
    int                longs;

    initial begin
        mismatches = 0;
        checked    = 0;
        shorts     = 0;
        longs      = 0;
    end

    // Debounce one raw sample against the tracked state and classify any release
    function automatic press_event_t classify(logic lvl, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] past_deadline;
        logic [TIME_W-1:0] held;
        deadline      = change_at + TIME_W'(deb_window);
        past_deadline = now - deadline;
        held          = now - press_at;
        if (hold_limit == '0)
            return EV_NONE;
        if (lvl != raw_seen) begin
            raw_seen  = lvl;
            change_at = now;
            return EV_NONE;
        end
        // bit 31 set means the deadline still lies ahead, across a wrap if need be
        if (lvl == debounced || past_deadline[TIME_W-1])
            return EV_NONE;
        debounced = lvl;
        if (lvl) begin
            if (!ignore_press)
                press_at = now;
            return EV_NONE;
        end
        if (ignore_press) begin
            ignore_press = 1'b0;
            return EV_NONE;
        end
        return (held >= TIME_W'(hold_limit)) ? EV_LONG : EV_SHORT;
    endfunction

    task automatic flag(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        press_event_t want;
        if (!aresetn) begin
            deb_window    = DEBOUNCE_TIME_RST;
            hold_limit    = LONG_PRESS_TIME_RST;
            raw_seen      = 1'b0;
            debounced     = 1'b0;
            ignore_press  = 1'b0;
            change_at     = '0;
            press_at      = '0;
            pending_events.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_DEBOUNCE_TIME)
                    deb_window = cfg_wdata;
                else
                    hold_limit = cfg_wdata;
            end
            // retire the result beat before taking a new sample beat
            if (m_tvalid && m_tready) begin
                checked++;
                if (pending_events.size() == 0) begin
                    flag($sformatf("result beat %0d with nothing expected, m_tdata %0h",
                                   checked, m_tdata));
                end else begin
                    want = pending_events.pop_front();
                    if (m_tdata != M_DATA_W'(want))
                        flag($sformatf("result beat %0d: expected %s, got m_tdata %0h",
                                       checked, want.name(), m_tdata));
                    if (want == EV_SHORT)
                        shorts++;
                    if (want == EV_LONG)
                        longs++;
                end
            end
            if (s_tvalid && s_tready) begin
                if (opcode_t'(s_tuser) == OP_INIT) begin
                    raw_seen     = s_tdata[0];
                    debounced    = s_tdata[0];
                    ignore_press = s_tdata[0];
                    change_at    = s_tdata[TIME_W:1];
                    press_at     = s_tdata[TIME_W:1];
                    pending_events.push_back(EV_NONE);
                end else begin
                    pending_events.push_back(classify(s_tdata[0], s_tdata[TIME_W:1]));
                end
            end
        end
        pending_results <= pending_events.size();
        mismatch_total  <= mismatches;
        results_checked <= checked;
        short_presses   <= shorts;
        long_presses    <= longs;
    end

endmodule

/* tb/button_debounce_press_classifier_tb.sv */
// Testbench top: clock, reset, sample stimulus, result back-pressure and verdict
`timescale 1ns / 1ps

module button_debounce_press_classifier_tb;
    import bdpc_pkg::*;

    localparam int ITEM_TARGET = 2000;
    localparam int STALL_LIMIT = 2000;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [0] pressed_level, [32:1] now_time, rest zero
    logic                s_tuser;   // [0] opcode
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // [1:0] press_event, rest zero

    int mismatch_total;
    int pending_results;
    int results_checked;
    int short_presses;
    int long_presses;

    logic [TIME_W-1:0] now_ms;
    logic [CFG_W-1:0]  deb_ms;
    logic [CFG_W-1:0]  lp_ms;
    int beats_sent;
    int useful_beats;
    int calm_left;
    int cfg_writes;
    int idle_cycles = 0;
    int stall_left  = 0;
    int ready_left  = 0;
    int phase_end;

    button_debounce_press_classifier u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    press_classifier_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_total  (mismatch_total),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .short_presses   (short_presses),
        .long_presses    (long_presses)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // Result side: alternate ready runs and stalls, now and then a long clean run
    always @(posedge aclk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
            m_tready   <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            ready_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(150, 400)
                                                      : $urandom_range(1, 30);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(opcode_t op, logic lvl, logic [TIME_W-1:0] t);
        int gap;
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 99) < 2)
                calm_left = $urandom_range(20, 80);
            gap = pick_gap();
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_DATA_W'({t, lvl});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        if (lp_ms != '0 || op == OP_INIT)
            useful_beats++;
    endtask

    task automatic send_sample(logic lvl, logic [TIME_W-1:0] dt);
        now_ms = now_ms + dt;
        send_beat(OP_SAMPLE, lvl, now_ms);
    endtask

    task automatic send_init(logic lvl, logic [TIME_W-1:0] dt);
        now_ms = now_ms + dt;
        send_beat(OP_INIT, lvl, now_ms);
    endtask

    task automatic bounce(logic lvl, int n);
        for (int i = 0; i < n; i++)
            send_sample(i[0] ? ~lvl : lvl, $urandom_range(0, 5));
    endtask

    // Move the raw level to lvl, then hold it until at least stay ms after the change
    task automatic settle(logic lvl, logic [TIME_W-1:0] first_dt, logic [TIME_W-1:0] stay);
        logic [TIME_W-1:0] mid;
        logic [TIME_W-1:0] extra;
        mid   = '0;
        extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : 0;
        send_sample(lvl, first_dt);
        if (stay > 0 && $urandom_range(0, 2) == 0) begin
            mid = $urandom_range(0, stay - 1);
            send_sample(lvl, mid);
        end
        send_sample(lvl, stay - mid + extra);
    endtask

    task automatic press_cycle();
        longint hold_ms;
        longint room;
        longint step;
        bounce(1'b1, $urandom_range(0, 3));
        settle(1'b1, $urandom_range(0, 50), TIME_W'(deb_ms));
        case ($urandom_range(0, 5))
            0:       hold_ms = longint'(lp_ms) - 1;
            1:       hold_ms = longint'(lp_ms);
            2:       hold_ms = longint'(lp_ms) + 1;
            3:       hold_ms = $urandom_range(0, 2 * int'(lp_ms) + 100);
            4:       hold_ms = $urandom_range(0, 300);
            default: hold_ms = $urandom_range(0, 100000);
        endcase
        // place the release so that it is accepted at least hold_ms after the press
        room = hold_ms - longint'(deb_ms);
        if (room > 1 && $urandom_range(0, 1) == 1) begin
            step = room / 2;
            send_sample(1'b1, TIME_W'(step));
            room = room - step;
        end
        if (room < 0)
            room = 0;
        if ($urandom_range(0, 3) == 0)
            bounce(1'b0, $urandom_range(1, 3));
        settle(1'b0, TIME_W'(room), TIME_W'(deb_ms));
    endtask

    task automatic noise_burst();
        logic [TIME_W-1:0] dt;
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 3))
                0:       dt = '0;
                1:       dt = $urandom_range(0, 2 * int'(deb_ms) + 2);
                2:       dt = $urandom();
                default: dt = $urandom_range(0, 10);
            endcase
            send_sample(1'($urandom_range(0, 1)), dt);
        end
    endtask

    task automatic random_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            press_cycle();
        end else if (r < 80) begin
            if ($urandom_range(0, 3) == 0)
                now_ms = ($urandom_range(0, 1) == 1) ? $urandom() : 32'hFFFF_FF00;
            send_init(1'($urandom_range(0, 1)), $urandom_range(0, 100));
        end else begin
            noise_burst();
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_DEBOUNCE_TIME)
            deb_ms = val;
        else
            lp_ms = val;
        cfg_writes++;
    endtask

    task automatic reconfigure();
        logic [CFG_W-1:0] deb;
        logic [CFG_W-1:0] lp;
        case ($urandom_range(0, 5))
            0:       deb = '0;
            1:       deb = 16'hFFFF;
            2:       deb = 16'd1;
            3, 4:    deb = CFG_W'($urandom_range(0, 60));
            default: deb = CFG_W'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 9))
            0:       lp = '0;
            1:       lp = 16'hFFFF;
            2:       lp = 16'd1;
            3, 4, 5: lp = CFG_W'($urandom_range(1, 3000));
            default: lp = CFG_W'($urandom_range(0, 65535));
        endcase
        drain();
        if ($urandom_range(0, 1) == 1) begin
            write_reg(CFG_DEBOUNCE_TIME, deb);
            write_reg(CFG_LONG_PRESS_TIME, lp);
        end else begin
            write_reg(CFG_LONG_PRESS_TIME, lp);
            write_reg(CFG_DEBOUNCE_TIME, deb);
        end
    endtask

    initial begin
        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_DEBOUNCE_TIME;
        cfg_wdata    <= '0;
        s_tvalid     <= 1'b0;
        s_tuser      <= OP_INIT;
        s_tdata      <= '0;
        m_tready     <= 1'b0;
        now_ms       = '0;
        deb_ms       = DEBOUNCE_TIME_RST;
        lp_ms        = LONG_PRESS_TIME_RST;
        beats_sent   = 0;
        useful_beats = 0;
        calm_left    = 0;
        cfg_writes   = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: sample straight out of reset, then init near the time wrap
        send_sample(1'b0, 0);
        now_ms = 32'hFFFF_FFF0;
        send_init(1'b0, 0);
        send_sample(1'b1, 5);
        send_sample(1'b1, 29);
        send_sample(1'b1, 1);              // press accepted across the wrap
        send_sample(1'b0, 970);
        send_sample(1'b0, 30);             // held exactly the long threshold
        send_sample(1'b1, 0);
        send_sample(1'b1, 30);
        send_sample(1'b0, 969);
        send_sample(1'b0, 30);             // one short of the threshold
        send_init(1'b1, 5);                // already held at init
        send_sample(1'b0, 10);
        send_sample(1'b0, 30);             // ignored release
        send_sample(1'b1, 0);
        send_sample(1'b1, 32'h8000_001E);  // deadline looks half a wrap away
        send_sample(1'b1, 32'h8000_0000);  // back on the deadline exactly
        send_sample(1'b0, 1);
        send_sample(1'b0, 30);

        // Zero debounce with a threshold of one
        drain();
        write_reg(CFG_DEBOUNCE_TIME, '0);
        write_reg(CFG_LONG_PRESS_TIME, 16'd1);
        send_sample(1'b1, 7);
        send_sample(1'b1, 0);
        send_sample(1'b0, 0);
        send_sample(1'b0, 0);
        send_sample(1'b0, 0);

        // Events disabled, then both registers at full scale
        drain();
        write_reg(CFG_LONG_PRESS_TIME, '0);
        write_reg(CFG_DEBOUNCE_TIME, 16'hFFFF);
        send_sample(1'b1, 3);
        send_sample(1'b1, 70000);
        drain();
        write_reg(CFG_LONG_PRESS_TIME, 16'hFFFF);
        now_ms = 32'hFFFF_FFFF;
        send_sample(1'b1, 0);
        send_sample(1'b1, 65535);
        send_sample(1'b0, 0);
        send_sample(1'b0, 65535);

        while (useful_beats < ITEM_TARGET) begin
            reconfigure();
            phase_end = beats_sent + ((lp_ms == '0) ? 40 : 200);
            while (beats_sent < phase_end && useful_beats < ITEM_TARGET)
                random_step();
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("Sent %0d sample/init beats over %0d register writes; checked %0d results",
                 beats_sent, cfg_writes, results_checked);
        $display("Classified %0d short and %0d long presses, %0d mismatches",
                 short_presses, long_presses, mismatch_total);
        if (mismatch_total == 0 && pending_results == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
